// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/irclt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package irclt_pkg;

	localparam int unsigned PARAM_COUNT_MAX = 255;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CH_UP_A  = 8'h41;

	localparam logic [1:0] KIND_PREFIX   = 2'd0;
	localparam logic [1:0] KIND_VERB     = 2'd1;
	localparam logic [1:0] KIND_PARAM    = 2'd2;
	localparam logic [1:0] KIND_TRAILING = 2'd3;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_BLANK        = 2'd1;
	localparam logic [1:0] ST_EMPTY_PREFIX = 2'd2;
	localparam logic [1:0] ST_NO_VERB      = 2'd3;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic [1:0] field_kind;
		logic [7:0] param_index;
		logic       token_start;
		logic       line_end;
		logic [1:0] status;
		logic       has_trailing;
		logic [7:0] param_count;
	} out_item_t;

endpackage

`default_nettype wire

// ----- rtl/irclt_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface irclt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/irc_line_tokenizer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// IRC line tokenizer.
// rx carries one byte of a message line per word (line_byte, last_byte).
// tx carries one result word for each byte that is kept as field data, and
// one for the last byte of every line even when that byte is dropped; the
// last result also carries status, has_trailing and param_count.
// A byte taken from rx is held in an input register and classified by a
// small mode machine; its result word goes into the output register that
// drives tx. Throughput: one byte per cycle while tx does not stall.
// When tx stalls, the output register holds its word and the input register
// holds the next byte; rx.ready then drops until tx takes the waiting word.
// Reset clears the mode machine, the counters and both valid flags; the
// block is ready for a new line right after reset. After each last byte the
// parser returns to its reset state by itself.
module irc_line_tokenizer_unit #(
	parameter int unsigned PARAM_COUNT_MAX = irclt_pkg::PARAM_COUNT_MAX
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	irclt_stream_if.sink   rx,
	irclt_stream_if.source tx
);

	localparam logic [3:0] M_SKIP        = 4'd0;
	localparam logic [3:0] M_PFX_FIRST   = 4'd1;
	localparam logic [3:0] M_PFX         = 4'd2;
	localparam logic [3:0] M_PFX_GAP     = 4'd3;
	localparam logic [3:0] M_VERB        = 4'd4;
	localparam logic [3:0] M_GAP         = 4'd5;
	localparam logic [3:0] M_PARAM       = 4'd6;
	localparam logic [3:0] M_TRAIL_FIRST = 4'd7;
	localparam logic [3:0] M_TRAIL       = 4'd8;
	localparam logic [3:0] M_ERR         = 4'd9;

	localparam logic [7:0] CNT_MAX = 8'(PARAM_COUNT_MAX);
	localparam logic [7:0] CASE_OFS = irclt_pkg::CH_LOW_A - irclt_pkg::CH_UP_A;

	logic                 valid_s1;
	irclt_pkg::in_item_t  item_s1;

	logic [3:0] mode_q;
	logic [7:0] params_q;
	logic       trail_q;
	logic [1:0] err_q;
	logic [7:0] slot_q;

	logic [3:0] nxt_mode;
	logic [7:0] nxt_params;
	logic       nxt_trail;
	logic [1:0] nxt_err;
	logic [7:0] nxt_slot;

	logic       cr_drop;
	logic [7:0] folded;
	logic       emit;
	logic [7:0] ch;
	logic [1:0] kind;
	logic [7:0] idx;
	logic       start;
	logic [1:0] status;
	logic       has_result;

	irclt_pkg::out_item_t res;
	irclt_pkg::out_item_t out_q;
	logic                 out_valid_q;

	logic out_free;
	logic adv;

	assign out_free = !out_valid_q || tx.ready;
	assign adv      = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;
	assign tx.valid = out_valid_q;
	assign tx.data  = out_q;

	assign cr_drop = item_s1.last_byte && (item_s1.line_byte == irclt_pkg::CH_CR);
	assign folded  = ((item_s1.line_byte >= irclt_pkg::CH_LOW_A) &&
	                  (item_s1.line_byte <= irclt_pkg::CH_LOW_Z)) ?
	                 (item_s1.line_byte - CASE_OFS) : item_s1.line_byte;

	always_comb begin
		nxt_mode   = mode_q;
		nxt_params = params_q;
		nxt_trail  = trail_q;
		nxt_err    = err_q;
		nxt_slot   = slot_q;
		emit       = 1'b0;
		ch         = 8'd0;
		kind       = irclt_pkg::KIND_PREFIX;
		idx        = 8'd0;
		start      = 1'b0;
		if (!cr_drop) begin
			case (mode_q)
				M_SKIP: begin
					if (item_s1.line_byte == irclt_pkg::CH_COLON) begin
						nxt_mode = M_PFX_FIRST;
					end else if (item_s1.line_byte != irclt_pkg::CH_SPACE) begin
						emit     = 1'b1;
						ch       = folded;
						kind     = irclt_pkg::KIND_VERB;
						start    = 1'b1;
						nxt_mode = M_VERB;
					end
				end
				M_PFX_FIRST: begin
					if (item_s1.line_byte == irclt_pkg::CH_SPACE) begin
						nxt_err  = irclt_pkg::ST_EMPTY_PREFIX;
						nxt_mode = M_ERR;
					end else begin
						emit     = 1'b1;
						ch       = item_s1.line_byte;
						start    = 1'b1;
						nxt_mode = M_PFX;
					end
				end
				M_PFX: begin
					if (item_s1.line_byte == irclt_pkg::CH_SPACE) begin
						nxt_mode = M_PFX_GAP;
					end else begin
						emit = 1'b1;
						ch   = item_s1.line_byte;
					end
				end
				M_PFX_GAP: begin
					if (item_s1.line_byte != irclt_pkg::CH_SPACE) begin
						emit     = 1'b1;
						ch       = folded;
						kind     = irclt_pkg::KIND_VERB;
						start    = 1'b1;
						nxt_mode = M_VERB;
					end
				end
				M_VERB: begin
					if (item_s1.line_byte == irclt_pkg::CH_SPACE) begin
						nxt_mode = M_GAP;
					end else begin
						emit = 1'b1;
						ch   = folded;
						kind = irclt_pkg::KIND_VERB;
					end
				end
				M_GAP: begin
					if (item_s1.line_byte == irclt_pkg::CH_COLON) begin
						nxt_trail = 1'b1;
						nxt_mode  = M_TRAIL_FIRST;
					end else if (item_s1.line_byte != irclt_pkg::CH_SPACE) begin
						// The new parameter takes the count as its index; the count stops at max.
						nxt_slot = params_q;
						if (params_q < CNT_MAX) begin
							nxt_params = params_q + 8'd1;
						end
						emit     = 1'b1;
						ch       = item_s1.line_byte;
						kind     = irclt_pkg::KIND_PARAM;
						idx      = params_q;
						start    = 1'b1;
						nxt_mode = M_PARAM;
					end
				end
				M_PARAM: begin
					if (item_s1.line_byte == irclt_pkg::CH_SPACE) begin
						nxt_mode = M_GAP;
					end else begin
						emit = 1'b1;
						ch   = item_s1.line_byte;
						kind = irclt_pkg::KIND_PARAM;
						idx  = slot_q;
					end
				end
				M_TRAIL_FIRST: begin
					emit     = 1'b1;
					ch       = item_s1.line_byte;
					kind     = irclt_pkg::KIND_TRAILING;
					idx      = params_q;
					start    = 1'b1;
					nxt_mode = M_TRAIL;
				end
				M_TRAIL: begin
					emit = 1'b1;
					ch   = item_s1.line_byte;
					kind = irclt_pkg::KIND_TRAILING;
					idx  = params_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (nxt_mode)
			M_SKIP:                        status = irclt_pkg::ST_BLANK;
			M_PFX_FIRST, M_PFX, M_PFX_GAP: status = irclt_pkg::ST_NO_VERB;
			M_VERB, M_GAP, M_PARAM,
			M_TRAIL_FIRST, M_TRAIL:        status = irclt_pkg::ST_OK;
			default:                       status = nxt_err;
		endcase
	end

	always_comb begin
		has_result       = emit || item_s1.last_byte;
		res.out_char     = ch;
		res.char_valid   = emit;
		res.field_kind   = kind;
		res.param_index  = idx;
		res.token_start  = start;
		res.line_end     = item_s1.last_byte;
		res.status       = item_s1.last_byte ? status : irclt_pkg::ST_OK;
		res.has_trailing = item_s1.last_byte && (status == irclt_pkg::ST_OK) && nxt_trail;
		res.param_count  = (item_s1.last_byte && (status == irclt_pkg::ST_OK)) ?
		                   nxt_params : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1 <= rx.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_SKIP;
			params_q <= 8'd0;
			trail_q  <= 1'b0;
			err_q    <= irclt_pkg::ST_OK;
			slot_q   <= 8'd0;
		end else if (adv) begin
			if (item_s1.last_byte) begin
				mode_q   <= M_SKIP;
				params_q <= 8'd0;
				trail_q  <= 1'b0;
				err_q    <= irclt_pkg::ST_OK;
				slot_q   <= 8'd0;
			end else begin
				mode_q   <= nxt_mode;
				params_q <= nxt_params;
				trail_q  <= nxt_trail;
				err_q    <= nxt_err;
				slot_q   <= nxt_slot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			out_q <= res;
		end
	end

	`AST_IMPLY(a_bare_word_is_line_end, clk, arst_n,
		tx.valid && !tx.data.char_valid, tx.data.line_end,
		"result word without a byte that does not end a line")
	`AST_IMPLY(a_error_has_no_summary, clk, arst_n,
		tx.valid && tx.data.line_end && (tx.data.status != irclt_pkg::ST_OK),
		!tx.data.has_trailing && (tx.data.param_count == 8'd0),
		"error status word carries a parameter summary")
	`AST_NEXT(a_line_end_resets_parser, clk, arst_n,
		adv && item_s1.last_byte,
		(mode_q == M_SKIP) && (params_q == 8'd0) && !trail_q,
		"parser state not cleared after the last byte of a line")
	`AST_IMPLY(a_count_bounded, clk, arst_n,
		1'b1, params_q <= CNT_MAX,
		"parameter count above its saturation limit")

endmodule

`default_nettype wire

// ----- tb/irc_line_tokenizer_unit_tb.sv -----
`timescale 1ns / 1ps

module irc_line_tokenizer_unit_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_COUNT  = 1100;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [3:0] {
		TOK_LEAD, TOK_PFX_OPEN, TOK_PFX_BODY, TOK_PFX_SPACE, TOK_VERB,
		TOK_ARG_SPACE, TOK_ARG, TOK_TAIL_OPEN, TOK_TAIL, TOK_BAD
	} tok_mode_t;

	typedef struct {
		irclt_pkg::in_item_t  word;
		bit                   typed;
		irclt_pkg::out_item_t want;
	} line_row_t;

	logic clk;
	logic arst_n;

	irclt_stream_if #(.payload_t(irclt_pkg::in_item_t))  line_ch ();
	irclt_stream_if #(.payload_t(irclt_pkg::out_item_t)) tok_ch ();

	irc_line_tokenizer_unit #(.PARAM_COUNT_MAX(irclt_pkg::PARAM_COUNT_MAX)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (line_ch),
		.tx     (tok_ch)
	);

	// Shadow copy of the parser state.
	tok_mode_t  tk_mode;
	logic [7:0] tk_args;
	logic [7:0] tk_slot;
	logic       tk_tail;
	logic [1:0] tk_err;

	irclt_pkg::out_item_t tok_expect_q[$];
	line_row_t            directed_q[$];
	logic [7:0]           line_q[$];

	int mismatches      = 0;
	int words_checked   = 0;
	int words_predicted = 0;
	int lines_sent      = 0;
	int bytes_sent      = 0;
	int burst_left      = 0;
	int cycles          = 0;
	int status_seen[4]  = '{0, 0, 0, 0};
	bit hold_done       = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function void clear_parser();
		tk_mode = TOK_LEAD;
		tk_args = '0;
		tk_slot = '0;
		tk_tail = 1'b0;
		tk_err  = irclt_pkg::ST_OK;
	endfunction

	function void add_byte(input logic [7:0] b);
		line_q = {line_q, b};
	endfunction

	function void add_row(input line_row_t r);
		directed_q = {directed_q, r};
	endfunction

	function automatic logic [7:0] fold_upper(input logic [7:0] b);
		if (b >= irclt_pkg::CH_LOW_A && b <= irclt_pkg::CH_LOW_Z) begin
			return b - irclt_pkg::CH_LOW_A + irclt_pkg::CH_UP_A;
		end
		return b;
	endfunction

	// Classifies one byte; returns 1 when the byte yields a result word.
	function automatic bit tokenize_byte(input irclt_pkg::in_item_t w,
			output irclt_pkg::out_item_t r);
		logic [7:0] b;
		bit emit;
		b = w.line_byte;
		emit = 1'b0;
		r = '0;
		// A CR that closes the line is stripped before parsing.
		if (!(w.last_byte && b == irclt_pkg::CH_CR)) begin
			case (tk_mode)
			TOK_LEAD: begin
				if (b == irclt_pkg::CH_COLON) begin
					tk_mode = TOK_PFX_OPEN;
				end else if (b != irclt_pkg::CH_SPACE) begin
					emit = 1'b1;
					r.out_char = fold_upper(b);
					r.field_kind = irclt_pkg::KIND_VERB;
					r.token_start = 1'b1;
					tk_mode = TOK_VERB;
				end
			end
			TOK_PFX_OPEN: begin
				if (b == irclt_pkg::CH_SPACE) begin
					tk_err = irclt_pkg::ST_EMPTY_PREFIX;
					tk_mode = TOK_BAD;
				end else begin
					emit = 1'b1;
					r.out_char = b;
					r.field_kind = irclt_pkg::KIND_PREFIX;
					r.token_start = 1'b1;
					tk_mode = TOK_PFX_BODY;
				end
			end
			TOK_PFX_BODY: begin
				if (b == irclt_pkg::CH_SPACE) begin
					tk_mode = TOK_PFX_SPACE;
				end else begin
					emit = 1'b1;
					r.out_char = b;
					r.field_kind = irclt_pkg::KIND_PREFIX;
				end
			end
			TOK_PFX_SPACE: begin
				// After a prefix even a colon starts the verb.
				if (b != irclt_pkg::CH_SPACE) begin
					emit = 1'b1;
					r.out_char = fold_upper(b);
					r.field_kind = irclt_pkg::KIND_VERB;
					r.token_start = 1'b1;
					tk_mode = TOK_VERB;
				end
			end
			TOK_VERB: begin
				if (b == irclt_pkg::CH_SPACE) begin
					tk_mode = TOK_ARG_SPACE;
				end else begin
					emit = 1'b1;
					r.out_char = fold_upper(b);
					r.field_kind = irclt_pkg::KIND_VERB;
				end
			end
			TOK_ARG_SPACE: begin
				if (b == irclt_pkg::CH_COLON) begin
					tk_tail = 1'b1;
					tk_mode = TOK_TAIL_OPEN;
				end else if (b != irclt_pkg::CH_SPACE) begin
					tk_slot = tk_args;
					if (tk_args < irclt_pkg::PARAM_COUNT_MAX) begin
						tk_args++;
					end
					emit = 1'b1;
					r.out_char = b;
					r.field_kind = irclt_pkg::KIND_PARAM;
					r.param_index = tk_slot;
					r.token_start = 1'b1;
					tk_mode = TOK_ARG;
				end
			end
			TOK_ARG: begin
				if (b == irclt_pkg::CH_SPACE) begin
					tk_mode = TOK_ARG_SPACE;
				end else begin
					emit = 1'b1;
					r.out_char = b;
					r.field_kind = irclt_pkg::KIND_PARAM;
					r.param_index = tk_slot;
				end
			end
			TOK_TAIL_OPEN, TOK_TAIL: begin
				emit = 1'b1;
				r.out_char = b;
				r.field_kind = irclt_pkg::KIND_TRAILING;
				r.param_index = tk_args;
				r.token_start = (tk_mode == TOK_TAIL_OPEN);
				tk_mode = TOK_TAIL;
			end
			default: begin
			end
			endcase
		end
		r.char_valid = emit;
		if (w.last_byte) begin
			r.line_end = 1'b1;
			case (tk_mode)
			TOK_LEAD: r.status = irclt_pkg::ST_BLANK;
			TOK_PFX_OPEN, TOK_PFX_BODY, TOK_PFX_SPACE: r.status = irclt_pkg::ST_NO_VERB;
			TOK_BAD: r.status = tk_err;
			default: r.status = irclt_pkg::ST_OK;
			endcase
			if (r.status == irclt_pkg::ST_OK) begin
				r.has_trailing = tk_tail;
				r.param_count = tk_args;
			end
			clear_parser();
		end
		return emit || w.last_byte;
	endfunction

	function automatic irclt_pkg::out_item_t end_only(input logic [1:0] st);
		irclt_pkg::out_item_t r;
		r = '0;
		r.line_end = 1'b1;
		r.status = st;
		return r;
	endfunction

	function automatic line_row_t row(input logic [7:0] b, input bit last,
			input bit typed = 1'b0, input irclt_pkg::out_item_t want = '0);
		line_row_t r;
		r.word.line_byte = b;
		r.word.last_byte = last;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
		0: return irclt_pkg::CH_SPACE;
		1: return irclt_pkg::CH_COLON;
		2: return irclt_pkg::CH_CR;
		3: return 8'($urandom_range(irclt_pkg::CH_LOW_A, irclt_pkg::CH_LOW_Z));
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_solid(input bit no_colon);
		logic [7:0] b;
		do begin
			b = pick_byte();
		end while (b == irclt_pkg::CH_SPACE || (no_colon && b == irclt_pkg::CH_COLON));
		return b;
	endfunction

	function void build_good_line();
		bit pfx;
		pfx = $urandom_range(0, 1);
		repeat ($urandom_range(0, 2)) add_byte(irclt_pkg::CH_SPACE);
		if (pfx) begin
			add_byte(irclt_pkg::CH_COLON);
			repeat ($urandom_range(1, 6)) add_byte(pick_solid(1'b0));
			repeat ($urandom_range(1, 2)) add_byte(irclt_pkg::CH_SPACE);
		end
		// Without a prefix a leading colon would open one, so the verb avoids it.
		add_byte((pfx && $urandom_range(0, 5) == 0) ? irclt_pkg::CH_COLON : pick_solid(!pfx));
		repeat ($urandom_range(0, 5)) add_byte(pick_solid(1'b0));
		repeat ($urandom_range(0, 5)) begin
			repeat ($urandom_range(1, 2)) add_byte(irclt_pkg::CH_SPACE);
			add_byte(pick_solid(1'b1));
			repeat ($urandom_range(0, 4)) add_byte(pick_solid(1'b0));
		end
		if ($urandom_range(0, 1)) begin
			repeat ($urandom_range(1, 2)) add_byte(irclt_pkg::CH_SPACE);
			add_byte(irclt_pkg::CH_COLON);
			repeat ($urandom_range(0, 8)) add_byte(pick_byte());
		end
		if ($urandom_range(0, 5) == 0) add_byte(irclt_pkg::CH_SPACE);
		if ($urandom_range(0, 2) == 0) add_byte(irclt_pkg::CH_CR);
	endfunction

	function void build_odd_line();
		case ($urandom_range(0, 4))
		0: repeat ($urandom_range(1, 3)) add_byte(irclt_pkg::CH_SPACE);
		1: begin
			add_byte(irclt_pkg::CH_COLON);
			add_byte(irclt_pkg::CH_SPACE);
			repeat ($urandom_range(0, 5)) add_byte(pick_byte());
		end
		2: begin
			add_byte(irclt_pkg::CH_COLON);
			repeat ($urandom_range(1, 4)) add_byte(pick_solid(1'b0));
			repeat ($urandom_range(0, 1)) add_byte(irclt_pkg::CH_SPACE);
		end
		3: repeat ($urandom_range(1, 8)) add_byte(pick_byte());
		default: add_byte(irclt_pkg::CH_CR);
		endcase
	endfunction

	// Offers one word in bursts separated by idle gaps and records its expected result.
	task automatic send_word(input irclt_pkg::in_item_t w, input bit typed,
			input irclt_pkg::out_item_t want);
		irclt_pkg::out_item_t guess;
		bit got;
		if (burst_left == 0) begin
			line_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 16);
		end
		line_ch.valid <= 1'b1;
		line_ch.data  <= w;
		@(posedge clk);
		while (!line_ch.ready) @(posedge clk);
		burst_left--;
		bytes_sent++;
		got = tokenize_byte(w, guess);
		if (typed) begin
			tok_expect_q = {tok_expect_q, want};
			words_predicted++;
		end else if (got) begin
			tok_expect_q = {tok_expect_q, guess};
			words_predicted++;
		end
	endtask

	task automatic send_line();
		irclt_pkg::in_item_t w;
		for (int i = 0; i < line_q.size(); i++) begin
			w.line_byte = line_q[i];
			w.last_byte = (i == line_q.size() - 1);
			send_word(w, 1'b0, '0);
		end
		line_q.delete();
		lines_sent++;
	endtask

	initial begin : stimulus
		irclt_pkg::out_item_t pfx_end;
		arst_n = 1'b0;
		line_ch.valid = 1'b0;
		line_ch.data = '0;
		clear_parser();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pfx_end = end_only(irclt_pkg::ST_NO_VERB);
		pfx_end.out_char = "x";
		pfx_end.char_valid = 1'b1;
		pfx_end.field_kind = irclt_pkg::KIND_PREFIX;
		pfx_end.token_start = 1'b1;

		add_row(row(irclt_pkg::CH_SPACE, 1'b1, 1'b1, end_only(irclt_pkg::ST_BLANK)));
		add_row(row(irclt_pkg::CH_CR, 1'b1, 1'b1, end_only(irclt_pkg::ST_BLANK)));
		add_row(row(irclt_pkg::CH_COLON, 1'b0));
		add_row(row(irclt_pkg::CH_SPACE, 1'b1, 1'b1, end_only(irclt_pkg::ST_EMPTY_PREFIX)));
		add_row(row(irclt_pkg::CH_COLON, 1'b0));
		add_row(row("x", 1'b1, 1'b1, pfx_end));
		// Verb folding at both ends of a-z, a colon inside a parameter, and a
		// trailing part holding a space, a mid-line CR and a zero byte.
		add_row(row("a", 1'b0));
		add_row(row("z", 1'b0));
		add_row(row(8'hFF, 1'b0));
		add_row(row(irclt_pkg::CH_SPACE, 1'b0));
		add_row(row("p", 1'b0));
		add_row(row(irclt_pkg::CH_COLON, 1'b0));
		add_row(row(irclt_pkg::CH_SPACE, 1'b0));
		add_row(row(irclt_pkg::CH_COLON, 1'b0));
		add_row(row(irclt_pkg::CH_SPACE, 1'b0));
		add_row(row(irclt_pkg::CH_CR, 1'b0));
		add_row(row(8'h00, 1'b1));
		// A colon right after the prefix is a verb byte; the final CR is dropped.
		add_row(row(irclt_pkg::CH_COLON, 1'b0));
		add_row(row("p", 1'b0));
		add_row(row(irclt_pkg::CH_SPACE, 1'b0));
		add_row(row(irclt_pkg::CH_COLON, 1'b0));
		add_row(row(irclt_pkg::CH_CR, 1'b1));
		add_row(row(irclt_pkg::CH_COLON, 1'b0));
		add_row(row("q", 1'b0));
		add_row(row(irclt_pkg::CH_SPACE, 1'b1));
		foreach (directed_q[i]) begin
			send_word(directed_q[i].word, directed_q[i].typed, directed_q[i].want);
		end

		// One line with more parameters than the counter can hold.
		add_byte("V");
		repeat (irclt_pkg::PARAM_COUNT_MAX + 5) begin
			add_byte(irclt_pkg::CH_SPACE);
			add_byte(pick_solid(1'b1));
		end
		add_byte(irclt_pkg::CH_SPACE);
		add_byte(irclt_pkg::CH_COLON);
		add_byte(8'h7E);
		send_line();

		while (bytes_sent < ITEM_COUNT) begin
			if ($urandom_range(0, 4) == 0) begin
				build_odd_line();
			end else begin
				build_good_line();
			end
			send_line();
		end
		line_ch.valid <= 1'b0;

		while (tok_expect_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("run: %0d lines, %0d bytes in, %0d result words checked, long hold-off %s",
			lines_sent, bytes_sent, words_checked, hold_done ? "done" : "missed");
		$display("line ends: ok %0d, blank %0d, empty prefix %0d, missing verb %0d",
			status_seen[irclt_pkg::ST_OK], status_seen[irclt_pkg::ST_BLANK],
			status_seen[irclt_pkg::ST_EMPTY_PREFIX], status_seen[irclt_pkg::ST_NO_VERB]);
		if (mismatches == 0 && tok_expect_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Receiver: randomly chosen ready patterns, plus one long hold-off that backs up the block.
	initial begin : tok_sink
		int len;
		int mode;
		logic [7:0] mask;
		tok_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && words_checked >= 150) begin
				tok_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				len = $urandom_range(10, 80);
				mode = $urandom_range(0, 2);
				mask = (mode == 0) ? 8'hFF : 8'($urandom_range(1, 255));
				for (int i = 0; i < len; i++) begin
					tok_ch.ready <= (mode == 2) ? 1'($urandom_range(0, 1)) : mask[i % 8];
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : tok_check
		irclt_pkg::out_item_t want;
		irclt_pkg::out_item_t got;
		bit bad;
		got = tok_ch.data;
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			if (tok_expect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at %0t: word %h arrived with nothing expected",
						$time, got);
				end
			end else begin
				want = tok_expect_q.pop_front();
				words_checked++;
				if (want.line_end) begin
					status_seen[want.status]++;
				end
				bad = (got.out_char !== want.out_char) || (got.char_valid !== want.char_valid)
					|| (got.field_kind !== want.field_kind)
					|| (got.param_index !== want.param_index)
					|| (got.token_start !== want.token_start)
					|| (got.line_end !== want.line_end) || (got.status !== want.status)
					|| (got.has_trailing !== want.has_trailing)
					|| (got.param_count !== want.param_count);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch at %0t (expected/actual): char %h/%h valid %b/%b",
							$time, want.out_char, got.out_char,
							want.char_valid, got.char_valid);
						$write(" kind %0d/%0d index %0d/%0d start %b/%b end %b/%b",
							want.field_kind, got.field_kind,
							want.param_index, got.param_index,
							want.token_start, got.token_start,
							want.line_end, got.line_end);
						$display(" status %0d/%0d trailing %b/%b count %0d/%0d",
							want.status, got.status, want.has_trailing, got.has_trailing,
							want.param_count, got.param_count);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
